// File: hw/rtl/acsnr_pkg.sv
// ----------------------------------------------------------------------------
// acsnr_pkg
// Shared constants and float classification helpers for the ALU constant
// shadow with NaN repair.
// ----------------------------------------------------------------------------
package acsnr_pkg;

    localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
    localparam logic [31:0] MANT_MASK = 32'h007F_FFFF;
    localparam logic [11:0] RUN_MAX   = 12'hFFF;

    localparam logic OP_WRITE   = 1'b0;
    localparam logic OP_OVERLAY = 1'b1;

    function automatic logic is_non_finite(input logic [31:0] v);
        return (v & EXP_MASK) == EXP_MASK;
    endfunction

    function automatic logic is_nan(input logic [31:0] v);
        return is_non_finite(v) && ((v & MANT_MASK) != 32'h0);
    endfunction

endpackage

// File: hw/rtl/alu_constant_shadow_nan_repair_top.sv
// ----------------------------------------------------------------------------
// alu_constant_shadow_nan_repair_top
// Shadow of the ALU constant file with published bits, repairing non-finite
// bank dwords from the shadow and zeroing unpublished NaNs.
// ----------------------------------------------------------------------------
// One transaction is taken per cycle while the input is not stalled. The
// shadow memory is read at the accepting edge (one read and one write port,
// data and published bit in one 33-bit word). Once the output register is
// free, the write or the overlay is applied, the totals advance and the
// result register is loaded, raising o_out_valid. Apart from the clearing
// pass, the input stalls only while a stalled result holds the output
// register. After reset a clearing pass sweeps all CONSTANT_COUNT*4 words
// (2048 at the default) and the published bits; the input stays stalled until it is done.
// ----------------------------------------------------------------------------
module alu_constant_shadow_nan_repair_top #(
    parameter int CONSTANT_COUNT = 512,
    parameter int WINDOW_BASE    = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [15:0] i_register_index,
    input  logic [10:0] i_dword_index,
    input  logic [31:0] i_value,
    input  logic        i_last_of_run,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_value_out,
    output logic        o_was_repaired,
    output logic        o_was_zeroed,
    output logic [11:0] o_run_repairs,
    output logic [63:0] o_written_total,
    output logic [63:0] o_repaired_total,
    output logic [63:0] o_zeroed_total,
    output logic [9:0]  o_seen_total
);

    localparam int          FILE_DWORDS = CONSTANT_COUNT * 4;
    localparam int          ADDR_W      = $clog2(FILE_DWORDS);
    localparam logic [16:0] FD17        = 17'(FILE_DWORDS);
    localparam logic [16:0] BASE17      = 17'(WINDOW_BASE);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(FILE_DWORDS - 1);
    localparam logic [ADDR_W-1:0] CLR_STEP = ADDR_W'(1);

    logic [32:0] mem [FILE_DWORDS];

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              r_s1_valid;
    logic              r_s1_op;
    logic              r_s1_last;
    logic              r_s1_hit;
    logic [31:0]       r_s1_val;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [32:0]       r_rd;

    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [31:0]       r_fwd_data;

    logic              r_out_valid;
    logic [31:0]       r_value_out;
    logic              r_was_repaired;
    logic              r_was_zeroed;
    logic [11:0]       r_run_out;
    logic [11:0]       r_run_cnt;
    logic [63:0]       r_write_cnt;
    logic [63:0]       r_repair_cnt;
    logic [63:0]       r_zero_cnt;
    logic [9:0]        r_seen_cnt;

    logic              en;
    logic              accept;
    logic [16:0]       reg17;
    logic [16:0]       off17;
    logic [16:0]       pos17;
    logic              in_hit;
    logic [ADDR_W-1:0] in_addr;

    logic [31:0]       sh_data;
    logic              sh_pub;
    logic              wr_en;
    logic              seen_inc;
    logic              repair;
    logic              zero;
    logic [31:0]       n_value_out;
    logic [11:0]       n_run_cnt;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_clr_busy || !en;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        reg17 = {1'b0, i_register_index};
        off17 = reg17 - BASE17;
        pos17 = {6'b0, i_dword_index};
        if (i_operation == acsnr_pkg::OP_OVERLAY) begin
            in_hit  = pos17 < FD17;
            in_addr = pos17[ADDR_W-1:0];
        end else begin
            in_hit  = (reg17 >= BASE17) && (off17 < FD17);
            in_addr = off17[ADDR_W-1:0];
        end
    end

    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            sh_data = r_fwd_data;
            sh_pub  = 1'b1;
        end else begin
            sh_data = r_rd[31:0];
            sh_pub  = r_rd[32];
        end
        wr_en       = 1'b0;
        seen_inc    = 1'b0;
        repair      = 1'b0;
        zero        = 1'b0;
        n_value_out = r_s1_val;
        n_run_cnt   = r_run_cnt;
        if (r_s1_op == acsnr_pkg::OP_WRITE) begin
            wr_en    = r_s1_hit && !acsnr_pkg::is_nan(r_s1_val);
            seen_inc = wr_en && (r_s1_addr[1:0] == 2'b00) && !sh_pub;
        end else if (r_s1_hit && acsnr_pkg::is_non_finite(r_s1_val)) begin
            if (sh_pub && !acsnr_pkg::is_non_finite(sh_data)) begin
                repair      = 1'b1;
                n_value_out = sh_data;
                if (r_run_cnt != acsnr_pkg::RUN_MAX) begin
                    n_run_cnt = r_run_cnt + 12'd1;
                end
            end else if (!sh_pub && ((r_s1_val & acsnr_pkg::MANT_MASK) != 32'h0)) begin
                zero        = 1'b1;
                n_value_out = 32'h0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= 33'h0;
        end else if (en && r_s1_valid && wr_en) begin
            mem[r_s1_addr] <= {1'b1, r_s1_val};
        end
        if (accept) begin
            r_rd <= mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_run_cnt   <= '0;
            r_write_cnt <= '0;
            r_repair_cnt <= '0;
            r_zero_cnt  <= '0;
            r_seen_cnt  <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + CLR_STEP;
                if (r_clr_addr == CLR_LAST) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (en) begin
                r_s1_valid  <= accept;
                r_out_valid <= r_s1_valid;
                r_fwd_valid <= r_s1_valid && wr_en;
                if (r_s1_valid) begin
                    if (wr_en) begin
                        r_write_cnt <= r_write_cnt + 64'd1;
                    end
                    if (seen_inc) begin
                        r_seen_cnt <= r_seen_cnt + 10'd1;
                    end
                    if (repair) begin
                        r_repair_cnt <= r_repair_cnt + 64'd1;
                    end
                    if (zero) begin
                        r_zero_cnt <= r_zero_cnt + 64'd1;
                    end
                    if (r_s1_op == acsnr_pkg::OP_OVERLAY && r_s1_last) begin
                        r_run_cnt <= '0;
                    end else begin
                        r_run_cnt <= n_run_cnt;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= i_operation;
            r_s1_last <= i_last_of_run;
            r_s1_hit  <= in_hit;
            r_s1_val  <= i_value;
            r_s1_addr <= in_addr;
        end
        if (en) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= r_s1_val;
        end
        if (en && r_s1_valid) begin
            r_value_out    <= n_value_out;
            r_was_repaired <= repair;
            r_was_zeroed   <= zero;
            r_run_out      <= n_run_cnt;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_value_out      = r_value_out;
    assign o_was_repaired   = r_was_repaired;
    assign o_was_zeroed     = r_was_zeroed;
    assign o_run_repairs    = r_run_out;
    assign o_written_total  = r_write_cnt;
    assign o_repaired_total = r_repair_cnt;
    assign o_zeroed_total   = r_zero_cnt;
    assign o_seen_total     = r_seen_cnt;

endmodule

// File: hw/rtl/acsnr_checker.sv
// ----------------------------------------------------------------------------
// acsnr_port_checks
// Port-level checks for the ALU constant shadow, bound to the top level.
// ----------------------------------------------------------------------------
module acsnr_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_value_out,
    input logic        o_was_repaired,
    input logic        o_was_zeroed,
    input logic [11:0] o_run_repairs
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled during clearing pass");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value_out))
        else $error("stalled result changed");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_was_repaired && o_was_zeroed))
        else $error("repaired and zeroed together");

    a_zeroed_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_zeroed |-> o_value_out == 32'h0)
        else $error("zeroed dword not zero");

    a_repair_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_was_repaired |-> o_run_repairs != 12'h0)
        else $error("repair missing from run count");

endmodule

bind alu_constant_shadow_nan_repair_top acsnr_port_checks u_acsnr_port_checks (.*);

// File: test/acsnr_checker.sv
// ----------------------------------------------------------------------------
// acsnr_checker
// Watches both channels of the ALU constant shadow block, keeps its own copy
// of the shadow file, published bits and totals, and compares every accepted
// result with the outcome predicted for the oldest outstanding transaction.
// ----------------------------------------------------------------------------
module acsnr_checker #(
    parameter int CONSTANT_COUNT = 512,
    parameter int WINDOW_BASE    = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_operation,
    input  logic [15:0] i_register_index,
    input  logic [10:0] i_dword_index,
    input  logic [31:0] i_value,
    input  logic        i_last_of_run,

    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_value_out,
    input  logic        i_was_repaired,
    input  logic        i_was_zeroed,
    input  logic [11:0] i_run_repairs,
    input  logic [63:0] i_written_total,
    input  logic [63:0] i_repaired_total,
    input  logic [63:0] i_zeroed_total,
    input  logic [9:0]  i_seen_total,

    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILE_DWORDS = CONSTANT_COUNT * 4;

    typedef struct packed {
        logic [31:0] value_out;
        logic        was_repaired;
        logic        was_zeroed;
        logic [11:0] run_repairs;
        logic [63:0] written_total;
        logic [63:0] repaired_total;
        logic [63:0] zeroed_total;
        logic [9:0]  seen_total;
    } t_dword_outcome;

    logic [31:0]    shadow_copy [FILE_DWORDS];
    logic           published   [FILE_DWORDS];
    logic [63:0]    write_count;
    logic [63:0]    repair_count;
    logic [63:0]    zero_count;
    logic [9:0]     seen_count;
    logic [11:0]    run_count;
    t_dword_outcome awaited_outcomes [$];
    t_dword_outcome wanted;
    t_dword_outcome observed;
    int             mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic t_dword_outcome resolve_dword(input logic op,
                                                     input logic [15:0] reg_idx,
                                                     input logic [10:0] pos,
                                                     input logic [31:0] val,
                                                     input logic last);
        t_dword_outcome res;
        int             rel;
        logic           val_nonfinite;
        logic           val_nan;
        val_nonfinite = (val[30:23] == 8'hFF);
        val_nan       = val_nonfinite && (val[22:0] != '0);
        res           = '0;
        res.value_out = val;
        if (op == acsnr_pkg::OP_WRITE) begin
            rel = int'(reg_idx) - WINDOW_BASE;
            if (rel >= 0 && rel < FILE_DWORDS && !val_nan) begin
                if (rel % 4 == 0 && !published[rel]) seen_count++;
                shadow_copy[rel] = val;
                published[rel]   = 1'b1;
                write_count++;
            end
            res.run_repairs = run_count;
        end else begin
            if (int'(pos) < FILE_DWORDS && val_nonfinite) begin
                if (published[pos] && shadow_copy[pos][30:23] != 8'hFF) begin
                    res.value_out    = shadow_copy[pos];
                    res.was_repaired = 1'b1;
                    repair_count++;
                    if (run_count != acsnr_pkg::RUN_MAX) run_count++;
                end else if (!published[pos] && val_nan) begin
                    res.value_out  = '0;
                    res.was_zeroed = 1'b1;
                    zero_count++;
                end
            end
            res.run_repairs = run_count;
            if (last) run_count = '0;
        end
        res.written_total  = write_count;
        res.repaired_total = repair_count;
        res.zeroed_total   = zero_count;
        res.seen_total     = seen_count;
        return res;
    endfunction

    function automatic string show(input t_dword_outcome o);
        return $sformatf("value=%h rep=%b zero=%b run=%0d wr=%0d rp=%0d zr=%0d seen=%0d",
                         o.value_out, o.was_repaired, o.was_zeroed, o.run_repairs,
                         o.written_total, o.repaired_total, o.zeroed_total,
                         o.seen_total);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FILE_DWORDS; i++) begin
                shadow_copy[i] = '0;
                published[i]   = 1'b0;
            end
            write_count  = '0;
            repair_count = '0;
            zero_count   = '0;
            seen_count   = '0;
            run_count    = '0;
            awaited_outcomes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                observed = {i_value_out, i_was_repaired, i_was_zeroed, i_run_repairs,
                            i_written_total, i_repaired_total, i_zeroed_total,
                            i_seen_total};
                if (awaited_outcomes.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result: %s", $realtime, show(observed));
                end else begin
                    wanted = awaited_outcomes.pop_front();
                    if (wanted != observed) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: mismatch expected %s", $realtime, show(wanted));
                            $display("%0t:          actual   %s", $realtime, show(observed));
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_outcomes.push_back(resolve_dword(i_operation, i_register_index,
                                                         i_dword_index, i_value,
                                                         i_last_of_run));
        end
        o_outstanding = awaited_outcomes.size();
    end

endmodule

// File: test/alu_constant_shadow_nan_repair_top_tb.sv
// ----------------------------------------------------------------------------
// alu_constant_shadow_nan_repair_top_tb
// Drives register writes and bank overlay transactions into the constant
// shadow block: a directed pass over the window edges, NaN and infinity
// cases, then random write runs and overlay banks under changing idle and
// stall rates and a long receiver hold-off. The checker beside the block
// does the comparing.
// ----------------------------------------------------------------------------
module alu_constant_shadow_nan_repair_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CONSTANT_COUNT = 512;
    localparam int WINDOW_BASE    = 16384;
    localparam int FILE_DWORDS    = CONSTANT_COUNT * 4;
    localparam int LONG_HOLD      = 150;
    localparam int CYCLE_LIMIT    = 60000;

    typedef enum {DW_FINITE, DW_INF, DW_NAN, DW_ANY} t_dword_kind;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic        i_operation      = acsnr_pkg::OP_WRITE;
    logic [15:0] i_register_index = '0;
    logic [10:0] i_dword_index    = '0;
    logic [31:0] i_value          = '0;
    logic        i_last_of_run    = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [31:0] o_value_out;
    logic        o_was_repaired;
    logic        o_was_zeroed;
    logic [11:0] o_run_repairs;
    logic [63:0] o_written_total;
    logic [63:0] o_repaired_total;
    logic [63:0] o_zeroed_total;
    logic [9:0]  o_seen_total;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    alu_constant_shadow_nan_repair_top #(
        .CONSTANT_COUNT(CONSTANT_COUNT),
        .WINDOW_BASE   (WINDOW_BASE)
    ) u_top (.*);

    acsnr_checker #(
        .CONSTANT_COUNT(CONSTANT_COUNT),
        .WINDOW_BASE   (WINDOW_BASE)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_register_index(i_register_index),
        .i_dword_index   (i_dword_index),
        .i_value         (i_value),
        .i_last_of_run   (i_last_of_run),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_value_out     (o_value_out),
        .i_was_repaired  (o_was_repaired),
        .i_was_zeroed    (o_was_zeroed),
        .i_run_repairs   (o_run_repairs),
        .i_written_total (o_written_total),
        .i_repaired_total(o_repaired_total),
        .i_zeroed_total  (o_zeroed_total),
        .i_seen_total    (o_seen_total),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    function automatic logic [31:0] pick_dword(input t_dword_kind kind);
        logic [31:0] bits;
        bits = $urandom;
        case (kind)
            DW_FINITE: if (bits[30:23] == 8'hFF) bits[30] = 1'b0;
            DW_INF:    bits[30:0] = {8'hFF, 23'h0};
            DW_NAN: begin
                bits[30:23] = 8'hFF;
                if (bits[22:0] == '0) bits[0] = 1'b1;
            end
            default: ;
        endcase
        return bits;
    endfunction

    function automatic int pick_pos();
        return ($urandom_range(99) < 70) ? int'($urandom_range(127))
                                         : int'($urandom_range(FILE_DWORDS - 1));
    endfunction

    task automatic offer(input logic op, input logic [15:0] reg_idx,
                         input logic [10:0] pos, input logic [31:0] val,
                         input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_register_index <= reg_idx;
        i_dword_index    <= pos;
        i_value          <= val;
        i_last_of_run    <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_run();
        int          len;
        int          pick;
        logic [15:0] base;
        len  = $urandom_range(1, 8);
        base = ($urandom_range(9) == 0) ? 16'($urandom) : 16'(WINDOW_BASE + pick_pos());
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            offer(acsnr_pkg::OP_WRITE, base + 16'(i), 11'($urandom),
                  pick_dword(pick < 60 ? DW_FINITE : pick < 75 ? DW_INF :
                             pick < 90 ? DW_NAN : DW_ANY),
                  i == len - 1 && $urandom_range(9) != 0);
        end
    endtask

    task automatic overlay_bank();
        int          len;
        int          pick;
        logic [10:0] base;
        len  = $urandom_range(1, 16);
        base = 11'(pick_pos());
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            offer(acsnr_pkg::OP_OVERLAY, 16'($urandom), base + 11'(i),
                  pick_dword(pick < 40 ? DW_INF : pick < 80 ? DW_NAN : DW_ANY),
                  i == len - 1 && $urandom_range(9) != 0);
        end
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                write_run();
            end else if (pick < 90) begin
                overlay_bank();
            end else begin
                offer(1'($urandom_range(1)), 16'($urandom), 11'($urandom), $urandom,
                      1'($urandom_range(1)));
            end
        end
    endtask

    task automatic directed_cases();
        offer(acsnr_pkg::OP_OVERLAY, 16'h0000, 11'd0,    32'h7FC0_0000, 1'b0);
        offer(acsnr_pkg::OP_OVERLAY, 16'hFFFF, 11'd2047, 32'h7F80_0000, 1'b0);
        offer(acsnr_pkg::OP_OVERLAY, 16'h0000, 11'd5,    32'h3F80_0000, 1'b1);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE), 11'd0, 32'h3F80_0000, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE + FILE_DWORDS - 1), 11'd2047,
              32'hFFFF_FFFF, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE + FILE_DWORDS - 1), 11'd0,
              32'hFF80_0000, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE - 1), 11'd0, 32'h4000_0000, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE + FILE_DWORDS), 11'd0,
              32'h4000_0000, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'hFFFF, 11'd2047, 32'h0000_0000, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'h0000, 11'd0,    32'h7F7F_FFFF, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE + 1), 11'd0, 32'h0000_0000, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE),     11'd0, 32'h4000_0000, 1'b1);
        offer(acsnr_pkg::OP_OVERLAY, 16'h0000, 11'd0,    32'hFFFF_FFFF, 1'b0);
        offer(acsnr_pkg::OP_OVERLAY, 16'h0000, 11'd2047, 32'h7FC0_0001, 1'b0);
        offer(acsnr_pkg::OP_OVERLAY, 16'h0000, 11'd1,    32'h7F80_0000, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE + 4), 11'd0, 32'h7F80_0001, 1'b0);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE + 4), 11'd0, 32'h7F80_0000, 1'b1);
        offer(acsnr_pkg::OP_OVERLAY, 16'h0000, 11'd4,    32'h7FFF_FFFF, 1'b1);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE + 8), 11'd0, 32'h7F7F_FFFF, 1'b0);
        offer(acsnr_pkg::OP_OVERLAY, 16'h0000, 11'd3,    32'hFF80_0001, 1'b1);
        offer(acsnr_pkg::OP_OVERLAY, 16'h0000, 11'd0,    32'h0000_0000, 1'b1);
        offer(acsnr_pkg::OP_OVERLAY, 16'h0000, 11'd8,    32'hFF80_0000, 1'b1);
        offer(acsnr_pkg::OP_WRITE, 16'(WINDOW_BASE), 11'd0, 32'h8000_0000, 1'b1);
    endtask

    initial begin : stimulus
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed_cases();
        drain_results();

        send_idle_pct  = 10;
        recv_stall_pct = 66;
        random_traffic(550);
        drain_results();

        send_idle_pct  = 66;
        recv_stall_pct = 10;
        random_traffic(550);
        drain_results();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req++;
        random_traffic(550);
        drain_results();

        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
